@@ design/kth_smallest_table_product_unit_macros.svh @@
// Assertion macros used by the top-level RTL file.
// Both macros compile to nothing when SYNTHESIS is defined.
`ifndef KTH_SMALLEST_TABLE_PRODUCT_UNIT_MACROS_SVH
`define KTH_SMALLEST_TABLE_PRODUCT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, off while in reset
`define KSTP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, off while in reset
`define KSTP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KSTP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define KSTP_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ design/kstp_pkg.sv @@
`default_nettype none

package kstp_pkg;

    localparam int DIM_W       = 11;
    localparam int RANK_W      = 21;
    localparam int VAL_W       = 21;
    localparam int CELL_W      = 2 * DIM_W;
    localparam int DIM_MAX_CODE = (2 ** DIM_W) - 1;
    localparam int MAX_DIM_DEF = 1024;

    // one quotient bit per divider cycle
    localparam int DIV_STEPS = CELL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

@@ design/kstp_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit a cycle.
module kstp_div
    import kstp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [CELL_W-1:0] dividend,
    input  wire logic [DIM_W-1:0]  divisor,
    output div_stat_t              stat,
    output logic      [CELL_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIM_W-1:0]     rem_reg, rem_next;
    logic [DIM_W-1:0]     dvs_reg, dvs_next;
    logic [CELL_W-1:0]    quo_reg, quo_next;
    logic [DIM_W:0]       trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[CELL_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = ge ? DIM_W'(trial - {1'b0, dvs_reg}) : DIM_W'(trial);
            quo_next = {quo_reg[CELL_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

@@ design/kth_smallest_table_product_unit.sv @@
// Rank zero or beyond rows*cols is settled in the check state; otherwise a binary search runs
//   P <= 21 probes, each walking up to S row terms through the divider, S the smaller dimension.
// Items: one at a time; the divider sets the pace, and a new item is taken only once the
//   last result has moved into the output register.
// Reset: aresetn synchronous, active low; clears the sequencer and output valid.
//   No storage needs clearing, so the block is ready the cycle after reset.
`default_nettype none

`include "kth_smallest_table_product_unit_macros.svh"

module kth_smallest_table_product_unit
    import kstp_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [DIM_W-1:0]  s_row_count,
    input  wire logic [DIM_W-1:0]  s_col_count,
    input  wire logic [RANK_W-1:0] s_rank,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [VAL_W-1:0]  m_kth_value,
    output logic                   m_found
);

    // Dimension cap; a MAX_DIM above the input range never bites.
    localparam logic [DIM_W-1:0] DIM_CAP =
        (MAX_DIM >= DIM_MAX_CODE) ? DIM_W'(DIM_MAX_CODE) : DIM_W'(MAX_DIM);

    // sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MULT      = 3'd1;  // table size product
    localparam logic [2:0] ST_CHECK     = 3'd2;  // rank zero / out of range
    localparam logic [2:0] ST_PROBE     = 3'd3;  // pick mid of search window
    localparam logic [2:0] ST_DIV_START = 3'd4;  // mid / idx
    localparam logic [2:0] ST_DIV_WAIT  = 3'd5;  // accumulate clamped quotient
    localparam logic [2:0] ST_NEXT      = 3'd6;  // window empty?
    localparam logic [2:0] ST_FINISH    = 3'd7;  // hand result to output reg

    logic [2:0]        state_reg, state_next;
    logic [DIM_W-1:0]  rows_reg, rows_next;
    logic [DIM_W-1:0]  cols_reg, cols_next;
    logic [RANK_W-1:0] k_reg, k_next;
    logic [CELL_W-1:0] cells_reg, cells_next;
    logic [DIM_W-1:0]  small_reg, small_next;
    logic [DIM_W-1:0]  big_reg, big_next;
    logic [CELL_W-1:0] lo_reg, lo_next;
    logic [CELL_W-1:0] hi_reg, hi_next;
    logic [CELL_W-1:0] ans_reg, ans_next;
    logic [CELL_W-1:0] mid_reg, mid_next;
    logic [DIM_W-1:0]  idx_reg, idx_next;
    logic [CELL_W-1:0] total_reg, total_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;
    logic              res_found_reg, res_found_next;
    logic              m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]  m_value_reg, m_value_next;
    logic              m_found_reg, m_found_next;

    logic              div_start;
    div_stat_t         div_stat;
    logic [CELL_W-1:0] div_quot;
    logic [CELL_W-1:0] q_clamped;
    logic [CELL_W-1:0] total_sum;

    // Shared divider: every row term of every probe goes through it.
    kstp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mid_reg),
        .divisor  (idx_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign div_start = (state_reg == ST_DIV_START);
    assign q_clamped = (div_quot > CELL_W'(big_reg)) ? CELL_W'(big_reg) : div_quot;
    assign total_sum = total_reg + q_clamped;

    always_comb begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        k_next         = k_reg;
        cells_next     = cells_reg;
        small_next     = small_reg;
        big_next       = big_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ans_next       = ans_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        res_value_next = res_value_reg;
        res_found_next = res_found_reg;
        m_value_next   = m_value_reg;
        m_found_next   = m_found_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rows_next  = (s_row_count > DIM_CAP) ? DIM_CAP : s_row_count;
                    cols_next  = (s_col_count > DIM_CAP) ? DIM_CAP : s_col_count;
                    k_next     = s_rank;
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                cells_next = CELL_W'(rows_reg) * CELL_W'(cols_reg);
                small_next = (rows_reg <= cols_reg) ? rows_reg : cols_reg;
                big_next   = (rows_reg <= cols_reg) ? cols_reg : rows_reg;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (k_reg == '0) begin
                    res_value_next = '0;
                    res_found_next = 1'b1;
                    state_next     = ST_FINISH;
                end else if (CELL_W'(k_reg) > cells_reg) begin
                    res_value_next = '0;
                    res_found_next = 1'b0;
                    state_next     = ST_FINISH;
                end else begin
                    lo_next    = CELL_W'(1);
                    hi_next    = cells_reg;
                    ans_next   = cells_reg;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                mid_next   = lo_reg + ((hi_reg - lo_reg) >> 1);
                total_next = '0;
                idx_next   = DIM_W'(1);
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    total_next = total_sum;
                    if (total_sum >= CELL_W'(k_reg)) begin
                        // count reached: mid is a candidate, search lower
                        ans_next   = mid_reg;
                        hi_next    = mid_reg - 1'b1;
                        state_next = ST_NEXT;
                    end else if (idx_reg == small_reg) begin
                        lo_next    = mid_reg + 1'b1;
                        state_next = ST_NEXT;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_NEXT: begin
                if (lo_reg <= hi_reg) begin
                    state_next = ST_PROBE;
                end else begin
                    res_value_next = ans_reg[VAL_W-1:0];
                    res_found_next = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_value_next = res_value_reg;
                    m_found_next = res_found_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        rows_reg      <= rows_next;
        cols_reg      <= cols_next;
        k_reg         <= k_next;
        cells_reg     <= cells_next;
        small_reg     <= small_next;
        big_reg       <= big_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        ans_reg       <= ans_next;
        mid_reg       <= mid_next;
        idx_reg       <= idx_next;
        total_reg     <= total_next;
        res_value_reg <= res_value_next;
        res_found_reg <= res_found_next;
        m_value_reg   <= m_value_next;
        m_found_reg   <= m_found_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_kth_value = m_value_reg;
    assign m_found     = m_found_reg;

    `KSTP_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `KSTP_ASSERT_IMP(a_not_found_zero, aclk, aresetn, m_valid && !m_found, m_kth_value == '0)
    `KSTP_ASSERT_IMP(a_probe_in_window, aclk, aresetn, state_reg == ST_DIV_START, lo_reg <= hi_reg && mid_reg >= lo_reg && mid_reg <= hi_reg)
    `KSTP_ASSERT_IMP(a_count_below_rank, aclk, aresetn, state_reg == ST_DIV_WAIT, total_reg < CELL_W'(k_reg))
    `KSTP_ASSERT_IMP(a_div_done_waited, aclk, aresetn, div_stat.done, state_reg == ST_DIV_WAIT)
    `KSTP_ASSERT_IMP(a_div_busy_waited, aclk, aresetn, div_stat.busy, state_reg == ST_DIV_WAIT)

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import kstp_pkg::*;

    localparam int TB_MAX_DIM   = MAX_DIM_DEF;
    localparam int ITEMS_PER_PH = 19;
    // exceeds the worst single item (1024 by 1024, rank at the top)
    localparam int STALL_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 40;
    // longer than any random item, so a second result backs up behind the first
    localparam int HOLD_CYCLES  = 30_000;
    localparam int RANK_TOP     = (2 ** RANK_W) - 1;

    typedef struct packed {
        logic [VAL_W-1:0] kth;
        logic             found;
    } product_result_t;

    // expectation attached to an offered item: typed in, or left to the predictor
    typedef struct {
        bit              typed;
        product_result_t res;
    } answer_hint_t;

    typedef struct {
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  cols;
        logic [RANK_W-1:0] rank;
        bit                typed;
        product_result_t   res;
    } directed_row_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [DIM_W-1:0]  s_row_count = '0;
    logic [DIM_W-1:0]  s_col_count = '0;
    logic [RANK_W-1:0] s_rank      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [VAL_W-1:0]  m_kth_value;
    logic              m_found;

    answer_hint_t      answer_hints[$];
    product_result_t   due_products[$];
    directed_row_t     directed_rows[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int fail_count     = 0;

    kth_smallest_table_product_unit #(
        .MAX_DIM (TB_MAX_DIM)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_row_count (s_row_count),
        .s_col_count (s_col_count),
        .s_rank      (s_rank),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kth_value (m_kth_value),
        .m_found     (m_found)
    );

    always #1 aclk = ~aclk;

    // Predictor: dimensions saturate at MAX_DIM, rank zero gives 0 with found
    // set, rank past rows*cols gives 0 with found clear. Otherwise a binary
    // search for the smallest x whose count of products <= x reaches the rank;
    // each count walks the smaller dimension and quits once the rank is hit.
    function automatic product_result_t kth_product(input logic [DIM_W-1:0]  row_in,
                                                    input logic [DIM_W-1:0]  col_in,
                                                    input logic [RANK_W-1:0] rank_in);
        longint unsigned rows, cols, k, cells, small_d, big_d;
        longint unsigned lo, hi, mid, ans, tally, q, i;
        bit              reached;
        product_result_t res;
        rows = row_in;
        cols = col_in;
        k    = rank_in;
        if (rows > TB_MAX_DIM) rows = TB_MAX_DIM;
        if (cols > TB_MAX_DIM) cols = TB_MAX_DIM;
        cells = rows * cols;
        res.kth   = '0;
        res.found = 1'b1;
        if (k == 0) return res;
        if (k > cells) begin
            res.found = 1'b0;
            return res;
        end
        small_d = (rows <= cols) ? rows : cols;
        big_d   = (rows <= cols) ? cols : rows;
        lo  = 1;
        hi  = cells;
        ans = cells;
        while (lo <= hi) begin
            mid     = lo + (hi - lo) / 2;
            tally   = 0;
            reached = 1'b0;
            for (i = 1; i <= small_d && !reached; i++) begin
                q = mid / i;
                if (q > big_d) q = big_d;
                tally += q;
                if (tally >= k) reached = 1'b1;
            end
            if (reached) begin
                ans = mid;
                hi  = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        res.kth = ans[VAL_W-1:0];
        return res;
    endfunction

    task automatic add_row(input int rows, input int cols, input int rank,
                           input bit typed, input int kth, input bit found);
        directed_row_t row;
        row.rows      = DIM_W'(rows);
        row.cols      = DIM_W'(cols);
        row.rank      = RANK_W'(rank);
        row.typed     = typed;
        row.res.kth   = VAL_W'(kth);
        row.res.found = found;
        directed_rows.push_back(row);
    endtask

    // Offer one item; returns in the time step of the edge that accepted it,
    // so the next call can keep valid high without a dip.
    task automatic offer_item(input logic [DIM_W-1:0]  rows,
                              input logic [DIM_W-1:0]  cols,
                              input logic [RANK_W-1:0] rank,
                              input bit                typed,
                              input product_result_t   res);
        answer_hint_t hint;
        hint.typed = typed;
        hint.res   = res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        answer_hints.push_back(hint);
        s_valid     <= 1'b1;
        s_row_count <= rows;
        s_col_count <= cols;
        s_rank      <= rank;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Monitor: signals read here are the values sampled at this edge, since
    // every driver updates them with nonblocking assignments.
    always @(posedge aclk) begin : monitor
        answer_hint_t    hint;
        product_result_t want;
        bit              progress;
        if (aresetn) begin
            progress = 1'b0;
            if (s_valid && s_ready) begin
                hint = answer_hints.pop_front();
                due_products.push_back(hint.typed ? hint.res
                                                  : kth_product(s_row_count, s_col_count,
                                                                s_rank));
                progress = 1'b1;
            end
            if (m_valid && m_ready) begin
                progress = 1'b1;
                if (due_products.size() == 0) begin
                    $error("result item with no expectation waiting: kth_value %0d found %0d",
                           m_kth_value, m_found);
                    fail_count++;
                end else begin
                    want = due_products.pop_front();
                    if (m_kth_value !== want.kth) begin
                        $error("kth_value: expected %0d, got %0d", want.kth, m_kth_value);
                        fail_count++;
                    end
                    if (m_found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, m_found);
                        fail_count++;
                    end
                end
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int              src_pcts[4];
        int              sink_pcts[4];
        int              ph, n, pick, lo_d, hi_d, rows, cols, rank;
        product_result_t none;
        none = '0;
        // phases: no idling, sender idle, receiver stalling, both
        src_pcts  = '{0, 50, 0, 18};
        sink_pcts = '{0, 0, 50, 18};

        // rows, cols, rank, typed, kth, found
        add_row(1,    1,    0,        1, 0,       1);  // rank zero
        add_row(1,    1,    1,        1, 1,       1);
        add_row(1,    1,    2,        1, 0,       0);  // rank past the table
        add_row(0,    5,    0,        1, 0,       1);  // empty table, rank zero
        add_row(0,    5,    1,        1, 0,       0);  // empty table
        add_row(7,    0,    3,        1, 0,       0);
        add_row(1024, 1024, 1,        1, 1,       1);
        add_row(1024, 1024, 1048576,  1, 1048576, 1);  // largest value, full walks
        add_row(1024, 1024, 1048577,  1, 0,       0);
        add_row(2047, 2047, RANK_TOP, 1, 0,       0);  // saturated, rank all ones
        add_row(2047, 1,    1024,     1, 1024,    1);  // rows saturate to 1024
        add_row(1,    2047, 1025,     1, 0,       0);
        add_row(1,    1024, 1000,     1, 1000,    1);
        add_row(2,    3,    6,        1, 6,       1);
        add_row(1536, 2,    2048,     1, 2048,    1);
        add_row(1,    1,    RANK_TOP, 1, 0,       0);
        add_row(5,    4,    0,        1, 0,       1);
        add_row(2,    1024, 1,        1, 1,       1);
        add_row(3,    3,    5,        0, 0,       0);
        add_row(10,   7,    35,       0, 0,       0);
        add_row(9,    1024, 4000,     0, 0,       0);
        add_row(1024, 9,    4000,     0, 0,       0);
        add_row(12,   12,   77,       0, 0,       0);
        add_row(31,   17,   300,      0, 0,       0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].rows, directed_rows[i].cols, directed_rows[i].rank,
                       directed_rows[i].typed, directed_rows[i].res);

        for (ph = 0; ph < 4; ph++) begin
            src_idle_pct   = src_pcts[ph];
            sink_stall_pct = sink_pcts[ph];
            // long hold-off on the result side so the block backs up its input
            if (ph == 2) hold_request = HOLD_CYCLES;
            for (n = 0; n < ITEMS_PER_PH; n++) begin
                pick = $urandom_range(99);
                lo_d = $urandom_range(1, 8);
                hi_d = $urandom_range(1, TB_MAX_DIM);
                if (pick < 70) begin
                    // well-formed: narrow table, rank inside it
                    rank = $urandom_range(1, lo_d * hi_d);
                end else if (pick < 80) begin
                    rank = $urandom_range(1) ? 0 : $urandom_range(lo_d * hi_d + 1, RANK_TOP);
                end else if (pick < 90) begin
                    // zero or oversized dimension against a narrow one
                    hi_d = $urandom_range(1) ? 0 : $urandom_range(TB_MAX_DIM + 1, 2047);
                    lo_d = $urandom_range(0, 8);
                    rank = $urandom_range(1) ? $urandom_range(0, 9000)
                                             : $urandom_range(0, RANK_TOP);
                end else begin
                    lo_d = $urandom_range(1, 40);
                    hi_d = $urandom_range(1, 40);
                    rank = $urandom_range(1, lo_d * hi_d);
                end
                if ($urandom_range(1)) begin
                    rows = lo_d;
                    cols = hi_d;
                end else begin
                    rows = hi_d;
                    cols = lo_d;
                end
                offer_item(DIM_W'(rows), DIM_W'(cols), RANK_W'(rank), 1'b0, none);
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (due_products.size() != 0 || answer_hints.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
